[hdl/utf8d_pkg.sv]
// shared types and constants of the utf-8 stream decoder
package utf8d_pkg;

   localparam int CP_W        = 21;
   localparam int USED_W      = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
   localparam logic [CP_W-1:0] MAX_SCALAR     = 21'h10FFFF;
   localparam logic [CP_W-1:0] MIN_TWO_BYTE   = 21'h000080;
   localparam logic [CP_W-1:0] MIN_THREE_BYTE = 21'h000800;
   localparam logic [CP_W-1:0] MIN_FOUR_BYTE  = 21'h010000;
   localparam logic [CP_W-1:0] SURROGATE_LO   = 21'h00D800;
   localparam logic [CP_W-1:0] SURROGATE_HI   = 21'h00DFFF;

   localparam logic [USED_W-1:0] LEN_NONE  = 3'd0;
   localparam logic [USED_W-1:0] LEN_ONE   = 3'd1;
   localparam logic [USED_W-1:0] LEN_TWO   = 3'd2;
   localparam logic [USED_W-1:0] LEN_THREE = 3'd3;
   localparam logic [USED_W-1:0] LEN_FOUR  = 3'd4;

   // one request: a byte of text
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } req_type;

   // one result: a code point or a replacement
   typedef struct packed {
      logic [CP_W-1:0]   code_point;
      logic              is_error;
      logic [USED_W-1:0] bytes_used;
      logic              run_last;
   } rsp_type;

   // work left for the back end by one request:
   // err_count replacements, then optionally one final result
   typedef struct packed {
      logic [USED_W-1:0] err_count;
      logic              has_final;
      logic [CP_W-1:0]   final_cp;
      logic              final_err;
      logic [USED_W-1:0] final_used;
   } cmd_type;

endpackage

[hdl/utf8_stream_decoder_top.sv]
// top level of the utf-8 stream decoder
//
// The req channel takes one byte of text per request, with end_of_text set
// on the last byte of a buffer to flush any partial sequence. The rsp channel
// gives one result per decoded scalar or per replacement, with bytes_used and
// run_last marking the last result caused by a byte.
// Both channels use valid/stall; a request moves when valid is high and stall
// is low. The front end decodes one byte per cycle while req_stall is low and
// writes a command into a four-entry queue; the back end expands commands
// into results. Throughput: one byte per cycle while each byte gives at most
// one result and rsp_stall is low. A byte that gives several results holds
// the back end's output register for each of them in turn, so error bursts
// (up to four replacements per byte) slow the flow. A result passes through
// the command queue, the back end's command stage and its output register.
// req_stall rises when the command queue is full, which happens only when
// rsp_stall holds the output or error bursts back up the queue.
// Reset (synchronous) clears the partial sequence, the queue and the output.
module utf8_stream_decoder_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  utf8d_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output utf8d_pkg::rsp_type rsp_data
);
   import utf8d_pkg::*;

   logic    accept;
   logic    push;
   cmd_type push_cmd;
   logic    q_full;
   logic    q_not_empty;
   logic    q_pop;
   cmd_type head_cmd;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // byte decode
   utf8d_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (push),
      .cmd      (push_cmd)
   );

   // command queue
   utf8d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   // result expansion
   utf8d_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_cmd       (head_cmd),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

[hdl/utf8d_front.sv]
// front end: takes bytes, tracks the partial sequence, emits result commands
module utf8d_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  utf8d_pkg::req_type  req_data,
   output logic              push,
   output utf8d_pkg::cmd_type  cmd
);
   import utf8d_pkg::*;

   logic [1:0]        pend_ff, pend_in;
   logic [USED_W-1:0] exp_ff, exp_in;
   logic [CP_W-1:0]   part_ff, part_in;

   logic [7:0]        b;
   logic              eot;
   logic              cont;
   logic [USED_W-1:0] count;
   logic [CP_W-1:0]   shifted;
   logic [CP_W-1:0]   min_val;
   logic              value_ok;
   logic              lead_ok;
   logic [USED_W-1:0] lead_len;
   logic [CP_W-1:0]   lead_val;

   assign b       = req_data.in_byte;
   assign eot     = req_data.end_of_text;
   assign cont    = (b[7:6] == 2'b10);
   assign count   = {1'b0, pend_ff} + LEN_ONE;
   assign shifted = {part_ff[CP_W-7:0], b[5:0]};

   // range checks on the completed value
   always_comb begin
      case (exp_ff)
         LEN_TWO:   min_val = MIN_TWO_BYTE;
         LEN_THREE: min_val = MIN_THREE_BYTE;
         default:   min_val = MIN_FOUR_BYTE;
      endcase
      value_ok = (shifted >= min_val) && (shifted <= MAX_SCALAR) &&
                 !((shifted >= SURROGATE_LO) && (shifted <= SURROGATE_HI));
   end

   // lead byte classification
   always_comb begin
      lead_ok  = 1'b1;
      lead_len = LEN_NONE;
      lead_val = '0;
      if (b[7:5] == 3'b110) begin
         lead_len = LEN_TWO;
         lead_val = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         lead_len = LEN_THREE;
         lead_val = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         lead_len = LEN_FOUR;
         lead_val = {18'd0, b[2:0]};
      end else begin
         lead_ok = 1'b0;
      end
   end

   // next sequence state and the command for the back end
   always_comb begin
      pend_in = pend_ff;
      exp_in  = exp_ff;
      part_in = part_ff;
      push    = 1'b0;
      cmd     = '0;
      if (accept) begin
         if ((exp_ff != LEN_NONE) && cont) begin
            if (count >= exp_ff) begin
               push = 1'b1;
               if (value_ok) begin
                  cmd.has_final  = 1'b1;
                  cmd.final_cp   = shifted;
                  cmd.final_used = exp_ff;
               end else begin
                  cmd.err_count = exp_ff;
               end
               pend_in = '0;
               exp_in  = LEN_NONE;
               part_in = '0;
            end else if (eot) begin
               push          = 1'b1;
               cmd.err_count = count;
               pend_in       = '0;
               exp_in        = LEN_NONE;
               part_in       = '0;
            end else begin
               pend_in = count[1:0];
               part_in = shifted;
            end
         end else begin
            // broken sequence: one replacement per pending byte
            if (exp_ff != LEN_NONE) begin
               push          = 1'b1;
               cmd.err_count = {1'b0, pend_ff};
               pend_in       = '0;
               exp_in        = LEN_NONE;
               part_in       = '0;
            end
            // decode this byte as a fresh start
            if (!b[7]) begin
               push           = 1'b1;
               cmd.has_final  = 1'b1;
               cmd.final_cp   = {13'd0, b};
               cmd.final_used = LEN_ONE;
            end else if (lead_ok && !eot) begin
               pend_in = 2'd1;
               exp_in  = lead_len;
               part_in = lead_val;
            end else begin
               push           = 1'b1;
               cmd.has_final  = 1'b1;
               cmd.final_cp   = REPLACEMENT_CP;
               cmd.final_err  = 1'b1;
               cmd.final_used = LEN_ONE;
            end
         end
      end
   end

   // sequence state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         exp_ff  <= LEN_NONE;
         part_ff <= '0;
      end else begin
         pend_ff <= pend_in;
         exp_ff  <= exp_in;
         part_ff <= part_in;
      end
   end

endmodule

[hdl/utf8d_queue.sv]
// small command queue between the front and back ends
module utf8d_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  utf8d_pkg::cmd_type push_cmd,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output utf8d_pkg::cmd_type head_cmd
);
   import utf8d_pkg::*;

   cmd_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   cnt_ff, cnt_in;

   assign full      = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   // pointers wrap naturally, depth is a power of two
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[hdl/utf8d_back.sv]
// back end: expands commands into results and holds the output register
module utf8d_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_not_empty,
   input  utf8d_pkg::cmd_type q_cmd,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output utf8d_pkg::rsp_type rsp_data
);
   import utf8d_pkg::*;

   logic              cur_valid_ff, cur_valid_in;
   cmd_type           cur_ff, cur_in;
   logic [USED_W-1:0] err_left_ff, err_left_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic              out_free;
   logic              adv;
   logic              cur_last;
   rsp_type           cur_rsp;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign adv      = cur_valid_ff && out_free;

   // result that the current command gives next
   always_comb begin
      cur_rsp = '0;
      if (err_left_ff != '0) begin
         cur_last            = (err_left_ff == LEN_ONE) && !cur_ff.has_final;
         cur_rsp.code_point  = REPLACEMENT_CP;
         cur_rsp.is_error    = 1'b1;
         cur_rsp.bytes_used  = LEN_ONE;
      end else begin
         cur_last            = 1'b1;
         cur_rsp.code_point  = cur_ff.final_cp;
         cur_rsp.is_error    = cur_ff.final_err;
         cur_rsp.bytes_used  = cur_ff.final_used;
      end
      cur_rsp.run_last = cur_last;
   end

   // command stage and output register
   always_comb begin
      q_pop        = q_not_empty && (!cur_valid_ff || (adv && cur_last));
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      err_left_in  = err_left_ff;
      if (adv) begin
         if (cur_last) begin
            cur_valid_in = 1'b0;
         end else begin
            err_left_in = err_left_ff - 1'b1;
         end
      end
      if (q_pop) begin
         cur_valid_in = 1'b1;
         cur_in       = q_cmd;
         err_left_in  = q_cmd.err_count;
      end
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_free) begin
         out_valid_in = adv;
         out_in       = cur_rsp;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         err_left_ff  <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         err_left_ff  <= err_left_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

[hdl/utf8d_checker.sv]
// port-level checks of the utf-8 stream decoder, bound to the top level
module utf8d_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input utf8d_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input utf8d_pkg::rsp_type rsp_data
);
   import utf8d_pkg::*;

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   // replacements consume exactly one byte
   a_error_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_error |->
         rsp_data.code_point == REPLACEMENT_CP && rsp_data.bytes_used == LEN_ONE)
      else $error("malformed replacement result");

   // good results are scalars, with a length of one to four
   a_good_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_error |->
         rsp_data.code_point <= MAX_SCALAR &&
         (rsp_data.code_point < SURROGATE_LO || rsp_data.code_point > SURROGATE_HI) &&
         rsp_data.bytes_used >= LEN_ONE && rsp_data.bytes_used <= LEN_FOUR)
      else $error("decoded result out of range");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind utf8_stream_decoder_top utf8d_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[bench/utf8_stream_decoder_top_tb.sv]
// self-checking bench for the utf-8 stream decoder: byte stimulus, decode prediction, result check
module utf8_stream_decoder_top_tb;
   import utf8d_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int NUM_PHASES  = 4;
   localparam int PHASE_BYTES = 102;
   localparam int MAX_REPORTS = 10;
   localparam int DRAIN_WAIT  = 8;

   // a pending text byte; hold makes the sender wait until every result is in
   typedef struct packed {
      req_type req;
      logic    hold;
   } text_item_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   text_item_type text_bytes[$];
   rsp_type       expected_points[$];

   // decoder state as the bench sees it
   logic [USED_W-1:0] seq_len;
   logic [1:0]        seq_seen;
   logic [CP_W-1:0]   seq_value;

   int idle_pct  = 0;
   int stall_pct = 0;
   int cycle_count = 0;
   int bytes_sent = 0;
   int results_seen = 0;
   int replacements_seen = 0;
   int fault_count = 0;

   utf8_stream_decoder_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // work out the code points and replacements that one accepted byte causes
   task automatic decode_byte(input req_type r);
      int              err_n;
      int              seen;
      int              i;
      logic            has_final;
      logic            start;
      logic [CP_W-1:0] v;
      logic [CP_W-1:0] floor_cp;
      logic [USED_W-1:0] lead_len;
      rsp_type         item;
      err_n     = 0;
      has_final = 1'b0;
      start     = 1'b0;
      lead_len  = LEN_NONE;
      item      = '0;
      if (seq_len != LEN_NONE) begin
         if (r.in_byte[7:6] == 2'b10) begin
            seen = int'(seq_seen) + 1;
            v = {seq_value[CP_W-7:0], r.in_byte[5:0]};
            if (seen >= int'(seq_len)) begin
               // sequence complete: reject overlong, surrogate and out of range
               floor_cp = (seq_len == LEN_TWO)   ? MIN_TWO_BYTE :
                          (seq_len == LEN_THREE) ? MIN_THREE_BYTE : MIN_FOUR_BYTE;
               if (v >= floor_cp && v <= MAX_SCALAR &&
                   !(v >= SURROGATE_LO && v <= SURROGATE_HI)) begin
                  has_final       = 1'b1;
                  item.code_point = v;
                  item.is_error   = 1'b0;
                  item.bytes_used = seq_len;
               end else begin
                  err_n = int'(seq_len);
               end
               seq_len = LEN_NONE; seq_seen = '0; seq_value = '0;
            end else if (r.end_of_text) begin
               // cut off by the end of the buffer
               err_n = seen;
               seq_len = LEN_NONE; seq_seen = '0; seq_value = '0;
            end else begin
               seq_seen  = seen[1:0];
               seq_value = v;
            end
         end else begin
            // not a continuation: flush what is pending, then decode afresh
            err_n = int'(seq_seen);
            seq_len = LEN_NONE; seq_seen = '0; seq_value = '0;
            start = 1'b1;
         end
      end else begin
         start = 1'b1;
      end

      // byte seen with nothing pending
      if (start) begin
         has_final = 1'b1;
         if (r.in_byte[7] == 1'b0) begin
            item.code_point = {13'd0, r.in_byte};
            item.is_error   = 1'b0;
            item.bytes_used = LEN_ONE;
         end else begin
            item.code_point = REPLACEMENT_CP;
            item.is_error   = 1'b1;
            item.bytes_used = LEN_ONE;
            if (r.in_byte[7:5] == 3'b110) begin
               lead_len = LEN_TWO;
               v = {16'd0, r.in_byte[4:0]};
            end else if (r.in_byte[7:4] == 4'b1110) begin
               lead_len = LEN_THREE;
               v = {17'd0, r.in_byte[3:0]};
            end else if (r.in_byte[7:3] == 5'b11110) begin
               lead_len = LEN_FOUR;
               v = {18'd0, r.in_byte[2:0]};
            end
            if (lead_len != LEN_NONE && !r.end_of_text) begin
               has_final = 1'b0;
               seq_len   = lead_len;
               seq_seen  = 2'd1;
               seq_value = v;
            end
         end
      end

      // queue replacements first, then the final result; mark the last one
      for (i = 0; i < err_n; i++) begin
         expected_points.push_back({REPLACEMENT_CP, 1'b1, LEN_ONE,
                                    (i == err_n - 1) && !has_final});
      end
      if (has_final) begin
         item.run_last = 1'b1;
         expected_points.push_back(item);
      end
   endtask

   function automatic void push_item(input logic [7:0] b, input logic eot, input logic hold);
      text_item_type t;
      t.req.in_byte     = b;
      t.req.end_of_text = eot;
      t.hold            = hold;
      text_bytes.push_back(t);
   endfunction

   // encode cp in len bytes (any value, so overlong and out of range too), keep the first few
   function automatic void push_seq(input logic [CP_W-1:0] cp, input int len, input int keep,
                                    input logic eot_last, input logic hold);
      logic [7:0] enc[4];
      int         i;
      case (len)
         1: begin
            enc[0] = {1'b0, cp[6:0]};
         end
         2: begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
         end
         3: begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
         end
         default: begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (i = 0; i < keep; i++) begin
         push_item(enc[i], eot_last && (i == keep - 1), hold && (i == 0));
      end
   endfunction

   // random text: mostly well-formed sequences, some noise and broken ones
   function automatic void add_random(input int n_bytes);
      int              target;
      int              kind;
      int              len;
      int              i;
      logic            hold;
      logic            eot;
      logic [7:0]      b;
      logic [CP_W-1:0] cp;
      target = text_bytes.size() + n_bytes;
      // first chunk of every phase waits for the previous results to drain
      hold = 1'b1;
      while (text_bytes.size() < target) begin
         kind = $urandom_range(99);
         eot  = ($urandom_range(9) == 0);
         if (kind < 60) begin
            len = $urandom_range(1, 4);
            case (len)
               1: cp = 21'($urandom_range(0, 21'h7F));
               2: cp = 21'($urandom_range(21'h80, 21'h7FF));
               3: begin
                  cp = 21'($urandom_range(21'h800, 21'hFFFF));
                  if (cp >= SURROGATE_LO && cp <= SURROGATE_HI)
                     cp = 21'($urandom_range(21'hE000, 21'hFFFF));
               end
               default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
            endcase
            push_seq(cp, len, len, eot, hold);
         end else if (kind < 70) begin
            push_item(8'($urandom_range(255)), ($urandom_range(3) == 0), hold);
         end else if (kind < 80) begin
            len = $urandom_range(2, 4);
            push_seq(21'($urandom), len, $urandom_range(1, len - 1),
                     1'($urandom_range(1)), hold);
         end else if (kind < 88) begin
            case ($urandom_range(2))
               0: begin
                  len = $urandom_range(2, 4);
                  cp = (len == 2) ? 21'($urandom_range(0, 21'h7F)) :
                       (len == 3) ? 21'($urandom_range(0, 21'h7FF)) :
                                    21'($urandom_range(0, 21'hFFFF));
               end
               1: begin
                  len = 3;
                  cp = 21'($urandom_range(SURROGATE_LO, SURROGATE_HI));
               end
               default: begin
                  len = 4;
                  cp = 21'($urandom_range(21'h110000, 21'h1FFFFF));
               end
            endcase
            push_seq(cp, len, len, eot, hold);
         end else if (kind < 94) begin
            len = $urandom_range(2, 4);
            push_seq(21'($urandom), len, $urandom_range(1, len - 1), 1'b0, hold);
            b = 8'($urandom_range(255));
            if (b[7:6] == 2'b10)
               b[6] = 1'b1;
            push_item(b, eot, 1'b0);
         end else begin
            len = $urandom_range(1, 3);
            for (i = 0; i < len; i++)
               push_item(8'($urandom_range(8'h80, 8'hBF)), eot && (i == len - 1),
                         hold && (i == 0));
         end
         hold = ($urandom_range(39) == 0);
      end
   endfunction

   // request driver: predict on acceptance, then load the next byte or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         seq_len   = LEN_NONE;
         seq_seen  = '0;
         seq_value = '0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_data);
            bytes_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (text_bytes.size() != 0 &&
                !(text_bytes[0].hold && expected_points.size() != 0) &&
                $urandom_range(99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= text_bytes[0].req;
               void'(text_bytes.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compare each accepted result with the oldest prediction
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_data.is_error)
               replacements_seen++;
            if (expected_points.size() == 0) begin
               if (fault_count < MAX_REPORTS)
                  $display("unexpected result: cp %h err %b used %0d last %b",
                           rsp_data.code_point, rsp_data.is_error,
                           rsp_data.bytes_used, rsp_data.run_last);
               fault_count++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_data.code_point !== want.code_point ||
                   rsp_data.is_error   !== want.is_error ||
                   rsp_data.bytes_used !== want.bytes_used ||
                   rsp_data.run_last   !== want.run_last) begin
                  if (fault_count < MAX_REPORTS)
                     $display("result %0d mismatch: exp %h %b %0d %b, got %h %b %0d %b",
                              results_seen, want.code_point, want.is_error,
                              want.bytes_used, want.run_last, rsp_data.code_point,
                              rsp_data.is_error, rsp_data.bytes_used, rsp_data.run_last);
                  fault_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, expected_points.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // stimulus sequencing through the idling phases
   initial begin : stimulus
      int phase_idle[NUM_PHASES];
      int phase_stall[NUM_PHASES];
      int p;
      phase_idle  = '{0, 76, 0, 30};
      phase_stall = '{0, 0, 76, 30};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (p = 0; p < NUM_PHASES; p++) begin
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         if (p == 0) begin
            // ascii extremes, one with the end mark
            push_item(8'h00, 1'b0, 1'b0);
            push_item(8'h7F, 1'b1, 1'b0);
            // smallest two-byte scalar and the largest scalar
            push_seq(21'h000080, 2, 2, 1'b0, 1'b0);
            push_seq(21'h10FFFF, 4, 4, 1'b0, 1'b0);
            // overlong with an always-invalid lead, surrogate, above range
            push_seq(21'h000000, 2, 2, 1'b0, 1'b0);
            push_seq(21'h00D800, 3, 3, 1'b0, 1'b0);
            push_seq(21'h110000, 4, 4, 1'b0, 1'b0);
            // stray continuation and invalid lead
            push_item(8'h80, 1'b0, 1'b0);
            push_item(8'hFF, 1'b0, 1'b0);
            // lead followed by a plain ascii byte
            push_item(8'hE2, 1'b0, 1'b0);
            push_item(8'h41, 1'b0, 1'b0);
            // four-byte sequence cut off by the end mark
            push_seq(21'h010000, 4, 3, 1'b1, 1'b0);
            // lead byte carrying the end mark
            push_item(8'hC3, 1'b1, 1'b0);
         end
         add_random(PHASE_BYTES);
         while (text_bytes.size() != 0 || req_valid || expected_points.size() != 0)
            @(posedge clock);
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      fault_count += expected_points.size();
      $display("sent %0d bytes over %0d idling phases in %0d cycles", bytes_sent,
               NUM_PHASES, cycle_count);
      $display("checked %0d results, %0d of them replacements, %0d faults", results_seen,
               replacements_seen, fault_count);
      if (fault_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
